// ----- hw/rtl/group_by_aggregate_assert.svh -----
// assertion macros for the group-by block
`ifndef GROUP_BY_AGGREGATE_ASSERT_SVH
`define GROUP_BY_AGGREGATE_ASSERT_SVH
`define GBA_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define GBA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

// ----- hw/rtl/gba_pkg.sv -----
// ----------------------------------------------------------------------------
// gba_pkg
// shared constants and types of the group-by aggregation block
// ----------------------------------------------------------------------------
package gba_pkg;
	localparam int MAX_ROWS = 64;
	localparam int IDX_W = $clog2(MAX_ROWS);
	localparam int CNT_W = 7;
	localparam logic [1:0] MODE_SUM = 2'd0;
	localparam logic [1:0] MODE_PROD = 2'd1;
	localparam logic [1:0] MODE_AVG = 2'd2;
	typedef struct packed {
		logic start;
		logic [1:0] mode;
		logic [CNT_W-1:0] cnt;
	} div_req_t;
endpackage

// ----- hw/rtl/gba_div.sv -----
// ----------------------------------------------------------------------------
// gba_div
// restoring divider, one quotient bit per cycle, signed 39-bit dividend by unsigned 7-bit divisor
// ----------------------------------------------------------------------------
module gba_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [38:0] dividend,
	input  logic [6:0]         divisor,
	output logic               done,
	output logic signed [31:0] quotient
);
	logic [38:0] mag_q;
	logic [38:0] quo_q;
	logic [7:0]  rem_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        run_q;
	logic [6:0]  dvs_q;
	logic [7:0]  trial;
	logic [38:0] qneg;
	assign trial = {rem_q[6:0], mag_q[38]};
	assign qneg = neg_q ? (~quo_q + 39'd1) : quo_q;
	assign quotient = qneg[31:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd39;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[38];
			mag_q <= dividend[38] ? (~dividend + 39'd1) : dividend;
			rem_q <= '0;
			quo_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			mag_q <= {mag_q[37:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial - {1'b0, dvs_q};
				quo_q <= {quo_q[37:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[37:0], 1'b0};
			end
		end
	end
endmodule

// ----- hw/rtl/group_by_aggregate.sv -----
// ----------------------------------------------------------------------------
// group_by_aggregate
// stores rows, sorts them by key, emits one aggregate per distinct key
// ----------------------------------------------------------------------------
// channel | signals                                  | handshake
// row in  | group_key row_value last_row             | start & !busy
// result  | out_key aggregate group_rows saturated.. | done strobe
// config  | cfg_we cfg_data                          | cfg_we
// a row is taken while idle, then busy in a gap state if it is not the last
// after the last row: stable insertion sort of n rows through one compare
// unit, on a read port and a write port of the key and value stores, then
// a pass over the sorted rows that sums each group, or multiplies in product
// mode (clipping each product), plus a divider run per group in average mode
// reset clears the row count and flags; stores need no clearing
// results cannot be stalled
module group_by_aggregate (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] group_key,
	input  logic signed [31:0] row_value,
	input  logic               last_row,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_data,
	output logic               done,
	output logic signed [31:0] out_key,
	output logic signed [31:0] aggregate,
	output logic [6:0]         group_rows,
	output logic               saturated,
	output logic               rows_dropped,
	output logic               last_group
);
	localparam logic [3:0] S_IDLE = 4'd0, S_GAP = 4'd1, S_SI = 4'd2, S_SRD = 4'd3,
		S_SCMP = 4'd4, S_SPUT = 4'd5, S_AFIRST = 4'd6, S_ARD = 4'd7,
		S_AUSE = 4'd8, S_AMUL = 4'd9, S_ADIV = 4'd10, S_EMIT = 4'd11,
		S_DROP = 4'd12;
	localparam int IW = gba_pkg::IDX_W;
	localparam int CW = gba_pkg::CNT_W;
	logic [3:0] st_q;
	logic [1:0] mode_q;
	logic [CW-1:0] n_q;
	logic ovf_q;
	logic [31:0] kmem [gba_pkg::MAX_ROWS];
	logic [31:0] vmem [gba_pkg::MAX_ROWS];
	logic [IW-1:0] ra;
	logic [31:0] rk_q, rv_q;
	logic we;
	logic [IW-1:0] wa;
	logic [31:0] wk, wv;
	logic [CW-1:0] i_q, j_q, p_q;
	logic signed [31:0] ck_q, cv_q, gk_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_s1;
	logic sat_q;
	logic [CW-1:0] gc_q;
	logic div_go_q;
	logic dstart, ddone;
	logic signed [31:0] dq;
	logic signed [63:0] pdiv;
	always_ff @(posedge clk) begin
		if (we) begin
			kmem[wa] <= wk;
			vmem[wa] <= wv;
		end
		rk_q <= kmem[ra];
		rv_q <= vmem[ra];
	end
	assign busy = st_q != S_IDLE;
	assign dstart = st_q == S_EMIT && mode_q == gba_pkg::MODE_AVG && !ddone && !div_go_q;
	assign pdiv = (prod_s1 < 0) ? -((-prod_s1) >>> 16) : (prod_s1 >>> 16);
	gba_div u_div (.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(acc_q[38:0]),
		.divisor(gc_q), .done(ddone), .quotient(dq));
	always_comb begin
		we = 1'b0;
		wa = i_q[IW-1:0];
		wk = group_key;
		wv = row_value;
		ra = j_q[IW-1:0];
		case (st_q)
			S_IDLE: begin
				we = start && (n_q < CW'(gba_pkg::MAX_ROWS));
				wa = n_q[IW-1:0];
			end
			S_SI: ra = i_q[IW-1:0];
			S_SRD: ra = j_q[IW-1:0] - IW'(1);
			S_SCMP: begin
				we = 1'b1;
				wa = j_q[IW-1:0];
				wk = rk_q;
				wv = rv_q;
			end
			S_SPUT: begin
				we = 1'b1;
				wa = j_q[IW-1:0];
				wk = ck_q;
				wv = cv_q;
			end
			default: ;
		endcase
		if (st_q == S_SCMP && !($signed(rk_q) > ck_q)) we = 1'b0;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			mode_q <= gba_pkg::MODE_SUM;
			n_q <= '0;
			ovf_q <= 1'b0;
			done <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) mode_q <= cfg_data;
			if (dstart) div_go_q <= 1'b1;
			else if (ddone) div_go_q <= 1'b0;
			case (st_q)
				S_IDLE: if (start) begin
					if (n_q < CW'(gba_pkg::MAX_ROWS)) n_q <= n_q + CW'(1);
					else ovf_q <= 1'b1;
					st_q <= last_row ? S_SI : S_GAP;
					i_q <= CW'(1);
				end
				S_GAP: st_q <= S_IDLE;
				S_SI: begin
					if (n_q == '0) st_q <= S_DROP;
					else if (i_q >= n_q) begin
						p_q <= '0;
						j_q <= '0;
						st_q <= S_AFIRST;
					end else begin
						j_q <= i_q;
						st_q <= S_SRD;
					end
				end
				S_SRD: begin
					if (j_q == i_q) begin
						ck_q <= rk_q;
						cv_q <= rv_q;
					end
					st_q <= S_SCMP;
				end
				S_SCMP: begin
					if ($signed(rk_q) > ck_q) begin
						j_q <= j_q - CW'(1);
						st_q <= (j_q == CW'(1)) ? S_SPUT : S_SRD;
					end else st_q <= S_SPUT;
				end
				S_SPUT: begin
					i_q <= i_q + CW'(1);
					st_q <= S_SI;
				end
				S_AFIRST: begin
					j_q <= p_q;
					st_q <= S_ARD;
					gc_q <= '0;
					sat_q <= 1'b0;
				end
				S_ARD: st_q <= S_AUSE;
				S_AUSE: begin
					if (gc_q == '0) begin
						gk_q <= rk_q;
						acc_q <= 64'($signed(rv_q));
						gc_q <= CW'(1);
						j_q <= j_q + CW'(1);
						st_q <= (j_q + CW'(1) < n_q) ? S_ARD : S_EMIT;
					end else if ($signed(rk_q) != gk_q) st_q <= S_EMIT;
					else begin
						gc_q <= gc_q + CW'(1);
						j_q <= j_q + CW'(1);
						if (mode_q == gba_pkg::MODE_PROD) begin
							prod_s1 <= 64'($signed(acc_q[31:0])) * 64'($signed(rv_q));
							st_q <= S_AMUL;
						end else begin
							acc_q <= acc_q + 64'($signed(rv_q));
							st_q <= (j_q + CW'(1) < n_q) ? S_ARD : S_EMIT;
						end
					end
				end
				S_AMUL: begin
					if (pdiv > 64'sd2147483647) begin
						acc_q <= 64'sd2147483647;
						sat_q <= 1'b1;
					end else if (pdiv < -64'sd2147483648) begin
						acc_q <= -64'sd2147483648;
						sat_q <= 1'b1;
					end else acc_q <= pdiv;
					st_q <= (j_q < n_q) ? S_ARD : S_EMIT;
				end
				S_EMIT: begin
					if (mode_q == gba_pkg::MODE_AVG && !ddone) p_q <= p_q;
					else begin
						done <= 1'b1;
						out_key <= gk_q;
						group_rows <= gc_q;
						rows_dropped <= ovf_q;
						last_group <= j_q >= n_q;
						saturated <= 1'b0;
						if (mode_q == gba_pkg::MODE_AVG) aggregate <= dq;
						else if (mode_q == gba_pkg::MODE_PROD) begin
							aggregate <= acc_q[31:0];
							saturated <= sat_q;
						end else if (acc_q > 64'sd2147483647) begin
							aggregate <= 32'h7fffffff;
							saturated <= 1'b1;
						end else if (acc_q < -64'sd2147483648) begin
							aggregate <= 32'h80000000;
							saturated <= 1'b1;
						end else aggregate <= acc_q[31:0];
						if (j_q >= n_q) st_q <= S_DROP;
						else begin
							p_q <= j_q;
							st_q <= S_AFIRST;
						end
					end
				end
				S_DROP: begin
					n_q <= '0;
					ovf_q <= 1'b0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/gba_checker.sv -----
// ----------------------------------------------------------------------------
// gba_checker
// port-level checks of the group-by aggregation block
// ----------------------------------------------------------------------------
`include "group_by_aggregate_assert.svh"
module gba_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [6:0] group_rows,
	input logic       last_group
);
	`GBA_ASSERT_IMPL(a_done_busy, clk, arst_n, done, busy)
	`GBA_ASSERT_IMPL(a_rows_nz, clk, arst_n, done, group_rows != 7'd0)
	`GBA_ASSERT_NEXT(a_take_busy, clk, arst_n, start && !busy, busy)
	`GBA_ASSERT_NEXT(a_last_end, clk, arst_n, done && last_group, !done)
endmodule
bind group_by_aggregate gba_checker u_chk (.clk(clk), .arst_n(arst_n), .start(start),
	.busy(busy), .done(done), .group_rows(group_rows), .last_group(last_group));

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// row-driven check of the group-by block: rows are loaded in data sets, and
// each set is sorted by key in the bench and aggregated (sum, product,
// average) to predict the per-group results, which are compared in order
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] key;
		logic signed [31:0] val;
		logic               last;
	} row_t;

	typedef struct {
		logic signed [31:0] key;
		logic signed [31:0] agg;
		logic [6:0]         cnt;
		logic               sat;
		logic               drop;
		logic               last;
	} group_res_t;

	typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_IDLE, PH_BOTH} phase_t;

	logic clk, arst_n;
	logic start, busy, last_row, cfg_we, done;
	logic signed [31:0] group_key, row_value;
	logic [1:0] cfg_data;
	logic signed [31:0] out_key, aggregate;
	logic [6:0] group_rows;
	logic saturated, rows_dropped, last_group;

	row_t       pending_rows[$];
	group_res_t expected_groups[$];
	phase_t     phase;
	int         errors;
	bit         hold_send;
	longint     cycles;

	// predictor state
	logic signed [31:0] set_keys[gba_pkg::MAX_ROWS];
	logic signed [31:0] set_vals[gba_pkg::MAX_ROWS];
	int                 set_count;
	bit                 set_overflow;
	logic [1:0]         mode_shadow;

	group_by_aggregate u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.group_key(group_key), .row_value(row_value), .last_row(last_row),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .out_key(out_key),
		.aggregate(aggregate), .group_rows(group_rows), .saturated(saturated),
		.rows_dropped(rows_dropped), .last_group(last_group)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic longint clip_word(longint v, ref bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	task automatic predict_groups(row_t r);
		int order[gba_pkg::MAX_ROWS];
		int i, j, s, e, cur;
		longint acc, total;
		bit sat;
		group_res_t g;
		if (set_count < gba_pkg::MAX_ROWS) begin
			set_keys[set_count] = r.key;
			set_vals[set_count] = r.val;
			set_count++;
		end else begin
			set_overflow = 1;
		end
		if (!r.last)
			return;
		for (i = 0; i < set_count; i++) begin
			cur = i;
			j = i;
			while (j > 0 && set_keys[order[j-1]] > set_keys[cur]) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = cur;
		end
		s = 0;
		while (s < set_count) begin
			e = s;
			sat = 0;
			while (e < set_count && set_keys[order[e]] == set_keys[order[s]])
				e++;
			if (mode_shadow == gba_pkg::MODE_PROD) begin
				acc = set_vals[order[s]];
				for (i = s + 1; i < e; i++)
					acc = clip_word((acc * longint'(set_vals[order[i]])) / 65536, sat);
			end else begin
				total = 0;
				for (i = s; i < e; i++)
					total += set_vals[order[i]];
				if (mode_shadow == gba_pkg::MODE_AVG)
					acc = total / (e - s);
				else
					acc = clip_word(total, sat);
			end
			g.key = set_keys[order[s]];
			g.agg = acc[31:0];
			g.cnt = 7'(e - s);
			g.sat = sat;
			g.drop = set_overflow;
			g.last = (e == set_count);
			expected_groups.push_back(g);
			s = e;
		end
		set_count = 0;
		set_overflow = 0;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			group_key <= 0;
			row_value <= 0;
			last_row <= 0;
		end else begin
			if (start && !busy) begin
				predict_groups(pending_rows.pop_front());
			end
			if ((!start || !busy) && !(start && busy)) begin
				if (pending_rows.size() > 0 && !hold_send &&
						!((phase == PH_SEND_IDLE || phase == PH_BOTH) &&
						$urandom_range(99) < 87)) begin
					start <= 1;
					group_key <= pending_rows[0].key;
					row_value <= pending_rows[0].val;
					last_row <= pending_rows[0].last;
				end else begin
					start <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		group_res_t g;
		if (arst_n && done) begin
			if (expected_groups.size() == 0) begin
				$display("%0t unexpected result key %0d agg %0d", $time, out_key, aggregate);
				errors++;
			end else begin
				g = expected_groups.pop_front();
				if (out_key !== g.key) begin
					$display("%0t key exp %0d got %0d", $time, g.key, out_key);
					errors++;
				end
				if (aggregate !== g.agg) begin
					$display("%0t aggregate exp %0d got %0d", $time, g.agg, aggregate);
					errors++;
				end
				if (group_rows !== g.cnt) begin
					$display("%0t group_rows exp %0d got %0d", $time, g.cnt, group_rows);
					errors++;
				end
				if (saturated !== g.sat) begin
					$display("%0t saturated exp %0d got %0d", $time, g.sat, saturated);
					errors++;
				end
				if (rows_dropped !== g.drop) begin
					$display("%0t rows_dropped exp %0d got %0d", $time, g.drop, rows_dropped);
					errors++;
				end
				if (last_group !== g.last) begin
					$display("%0t last_group exp %0d got %0d", $time, g.last, last_group);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed(32'($urandom_range(200000)) - 32'sd100000);
			3: return $signed(32'($urandom_range(1 << 18)) - 32'sd131072);
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic add_set(int n, int nkeys, bit wide);
		row_t r;
		int i;
		for (i = 0; i < n; i++) begin
			r.key = wide ? $signed($urandom()) :
				$signed(32'($urandom_range(nkeys - 1)) - 32'sd2);
			r.val = rand_word();
			r.last = (i == n - 1);
			pending_rows.push_back(r);
		end
	endtask

	task automatic wait_drained();
		while (pending_rows.size() > 0 || start || expected_groups.size() > 0)
			@(posedge clk);
		repeat (12000) @(posedge clk);
	endtask

	task automatic set_mode(logic [1:0] m);
		@(posedge clk);
		cfg_we <= 1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 0;
		mode_shadow = (m == 2'd3) ? gba_pkg::MODE_SUM : m;
		if (m == gba_pkg::MODE_AVG) mode_shadow = gba_pkg::MODE_AVG;
		if (m == gba_pkg::MODE_PROD) mode_shadow = gba_pkg::MODE_PROD;
	endtask

	task automatic push_row(logic signed [31:0] k, logic signed [31:0] v, logic l);
		row_t r;
		r.key = k;
		r.val = v;
		r.last = l;
		pending_rows.push_back(r);
	endtask

	initial begin
		int p, m;
		errors = 0;
		cycles = 0;
		hold_send = 0;
		phase = PH_FREE;
		cfg_we = 0;
		cfg_data = 0;
		set_count = 0;
		set_overflow = 0;
		mode_shadow = gba_pkg::MODE_SUM;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		// directed: extremes, saturation, single row set, equal keys
		push_row(32'sh7fffffff, 32'sh7fffffff, 0);
		push_row(32'sh7fffffff, 32'sh7fffffff, 0);
		push_row(32'sh80000000, 32'sh80000000, 0);
		push_row(32'sh80000000, 32'sh80000000, 0);
		push_row(0, -1, 0);
		push_row(0, 1, 1);
		push_row(5, 32'sh00010000, 1);
		wait_drained();
		set_mode(gba_pkg::MODE_PROD);
		push_row(1, 32'sh7fffffff, 0);
		push_row(1, 32'sh7fffffff, 0);
		push_row(-1, -32'sh00030000, 0);
		push_row(-1, 32'sh00020000, 1);
		wait_drained();
		set_mode(gba_pkg::MODE_AVG);
		push_row(3, -7, 0);
		push_row(3, 2, 0);
		push_row(-3, 32'sh80000000, 0);
		push_row(-3, 32'sh80000000, 1);
		wait_drained();
		set_mode(2'd3);
		add_set(gba_pkg::MAX_ROWS + 3, 4, 0);
		wait_drained();
		// random phases
		for (p = 0; p < 9; p++) begin
			phase = phase_t'(p % 4);
			m = $urandom_range(3);
			set_mode(m[1:0]);
			repeat (3) begin
				case ($urandom_range(9))
					0: add_set(gba_pkg::MAX_ROWS + $urandom_range(4), 1 + $urandom_range(8), 0);
					1: add_set(1 + $urandom_range(4), 1, 1);
					default: add_set(1 + $urandom_range(9), 1 + $urandom_range(5), 0);
				endcase
			end
			if (p == 5) begin
				hold_send = 1;
				while (start || expected_groups.size() > 0) @(posedge clk);
				repeat (12000) @(posedge clk);
				hold_send = 0;
			end
			wait_drained();
		end
		set_mode(gba_pkg::MODE_SUM);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ----- group_by_aggregate.f -----
+incdir+hw/rtl
hw/rtl/gba_pkg.sv
hw/rtl/gba_div.sv
hw/rtl/group_by_aggregate.sv
hw/rtl/gba_checker.sv
bench/tb_top.sv
